[sv/frustum_cull_test_unit_macros.svh]
// assertion helpers for the frustum cull unit
`ifndef FRUSTUM_CULL_TEST_UNIT_MACROS_SVH
`define FRUSTUM_CULL_TEST_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every edge once reset is released
`define FCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define FCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define FCT_ASSERT(lbl, prop, msg)
`define FCT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[sv/fct_pkg.sv]
package fct_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadW    = 15;
  localparam int unsigned MarginW = 16;
  localparam int unsigned PlaneW  = 64;
  localparam int unsigned ProdW   = 2 * CoordW;
  // three products, one offset term and headroom
  localparam int unsigned DistW   = 35;
  // offset Q12.4 lifted to 18 fraction bits
  localparam int unsigned OffShift = 14;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_BOX    = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [CoordW-1:0] d;
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [CoordW-1:0] lo_x;
    logic signed [CoordW-1:0] lo_y;
    logic signed [CoordW-1:0] lo_z;
    logic signed [CoordW-1:0] hi_x;
    logic signed [CoordW-1:0] hi_y;
    logic signed [CoordW-1:0] hi_z;
    logic [RadW-1:0]          rad;
  } item_t;

  // normal times both corner triples, one plane
  typedef struct packed {
    logic signed [ProdW-1:0] lx;
    logic signed [ProdW-1:0] ly;
    logic signed [ProdW-1:0] lz;
    logic signed [ProdW-1:0] hx;
    logic signed [ProdW-1:0] hy;
    logic signed [ProdW-1:0] hz;
  } prod_t;

endpackage

[sv/frustum_cull_test_unit.sv]
// Frustum cull unit: tests a point, a sphere or an axis-aligned box against
// six planes held in configuration and answers inside_res_o = 1 when the
// object passes every plane. One item is accepted per cycle unless the input
// stalls; its answer passes the input register, product register and result
// register. Throughput is one item per clock while the output is not stalled,
// set by the parallel plane lanes with six 16x16 multipliers each; a stalled
// result holds its stage, and items behind it move only into empty stages.
// Distances are exact with 18 fraction bits. Planes and point margin may only
// be written while no item is in flight. An unused kind code answers 0.
`include "frustum_cull_test_unit_macros.svh"

module frustum_cull_test_unit #(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [$clog2(PLANE_COUNT+1)-1:0]       cfg_idx_i,
  input  logic [fct_pkg::PlaneW-1:0]             cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             kind_i,
  input  logic signed [fct_pkg::CoordW-1:0]      first_x_i,
  input  logic signed [fct_pkg::CoordW-1:0]      first_y_i,
  input  logic signed [fct_pkg::CoordW-1:0]      first_z_i,
  input  logic signed [fct_pkg::CoordW-1:0]      second_x_i,
  input  logic signed [fct_pkg::CoordW-1:0]      second_y_i,
  input  logic signed [fct_pkg::CoordW-1:0]      second_z_i,
  input  logic [fct_pkg::RadW-1:0]               radius_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   inside_res_o
);
  import fct_pkg::*;

  localparam int unsigned IdxW = $clog2(PLANE_COUNT + 1);
  localparam logic [IdxW-1:0] MarginIdx = IdxW'(PLANE_COUNT);

  plane_t             planes_q [PLANE_COUNT];
  logic [MarginW-1:0] margin_q;

  logic               a_valid_q, b_valid_q, out_valid_q;
  item_t              item_q;
  logic [1:0]         kind_b_q;
  logic [RadW-1:0]    rad_b_q;
  logic               inside_q, inside_d;
  logic               en_a, en_b, en_c;
  prod_t              prod [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] fail;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        planes_q[i] <= '0;
      end
      margin_q <= MarginW'(1);
    end else if (cfg_we_i) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (cfg_idx_i == IdxW'(i)) begin
          planes_q[i] <= plane_t'(cfg_wdata_i);
        end
      end
      if (cfg_idx_i == MarginIdx) begin
        margin_q <= cfg_wdata_i[MarginW-1:0];
      end
    end
  end

  // each stage moves on when the next one is empty or moving
  assign en_c       = !out_valid_q || !out_stall_i;
  assign en_b       = !b_valid_q || en_c;
  assign en_a       = !a_valid_q || en_b;
  assign in_stall_o = !en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_q <= in_valid_i;
      end
      if (en_b) begin
        b_valid_q <= a_valid_q;
      end
      if (en_c) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      item_q.kind <= kind_i;
      item_q.lo_x <= first_x_i;
      item_q.lo_y <= first_y_i;
      item_q.lo_z <= first_z_i;
      item_q.hi_x <= second_x_i;
      item_q.hi_y <= second_y_i;
      item_q.hi_z <= second_z_i;
      item_q.rad  <= radius_i;
    end
    if (en_b && a_valid_q) begin
      kind_b_q <= item_q.kind;
      rad_b_q  <= item_q.rad;
    end
    if (en_c && b_valid_q) begin
      inside_q <= inside_d;
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fct_prod u_prod (
      .clk_i   (clk_i),
      .load_i  (en_b && a_valid_q),
      .plane_i (planes_q[p]),
      .item_i  (item_q),
      .prod_o  (prod[p])
    );

    fct_judge u_judge (
      .prod_i   (prod[p]),
      .plane_i  (planes_q[p]),
      .kind_i   (kind_b_q),
      .rad_i    (rad_b_q),
      .margin_i (margin_q),
      .fail_o   (fail[p])
    );
  end

  assign inside_d     = ~|fail;
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  // unused kind code never reports inside
  `FCT_ASSERT(a_bad_kind, b_valid_q && en_c && (kind_b_q == KIND_UNUSED) |=> !inside_q, "unused kind passed")
  // input only stalls when every stage holds an item
  `FCT_ASSERT(a_stall_full, in_stall_o |-> (a_valid_q && b_valid_q && out_valid_q), "stall with a bubble")
  // a blocked middle stage keeps its item
  `FCT_ASSERT(a_b_hold, b_valid_q && !en_c |=> b_valid_q, "item dropped in product stage")
  // margin write lands
  `FCT_ASSERT(a_margin_wr, cfg_we_i && (cfg_idx_i == MarginIdx) |=> margin_q == $past(cfg_wdata_i[MarginW-1:0]), "margin write lost")
  // no result right after a reset edge
  `FCT_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_q, "result during reset")

endmodule

[sv/fct_prod.sv]
module fct_prod (
  input  logic            clk_i,
  input  logic            load_i,
  input  fct_pkg::plane_t plane_i,
  input  fct_pkg::item_t  item_i,
  output fct_pkg::prod_t  prod_o
);
  import fct_pkg::*;

  prod_t prod_d, prod_q;

  always_comb begin
    prod_d.lx = plane_i.nx * item_i.lo_x;
    prod_d.ly = plane_i.ny * item_i.lo_y;
    prod_d.lz = plane_i.nz * item_i.lo_z;
    prod_d.hx = plane_i.nx * item_i.hi_x;
    prod_d.hy = plane_i.ny * item_i.hi_y;
    prod_d.hz = plane_i.nz * item_i.hi_z;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[sv/fct_judge.sv]
module fct_judge (
  input  fct_pkg::prod_t                  prod_i,
  input  fct_pkg::plane_t                 plane_i,
  input  logic [1:0]                      kind_i,
  input  logic [fct_pkg::RadW-1:0]        rad_i,
  input  logic [fct_pkg::MarginW-1:0]     margin_i,
  output logic                            fail_o
);
  import fct_pkg::*;

  logic signed [DistW-1:0] off_term;
  logic signed [DistW-1:0] dist_pt;
  logic signed [DistW-1:0] dist_box;
  logic signed [DistW-1:0] neg_rad;
  logic signed [DistW-1:0] margin_ext;
  logic signed [ProdW-1:0] max_x, max_y, max_z;

  always_comb begin
    off_term   = $signed({{(DistW-CoordW-OffShift){plane_i.d[CoordW-1]}},
                          plane_i.d, {OffShift{1'b0}}});
    dist_pt    = DistW'(prod_i.lx) + DistW'(prod_i.ly) + DistW'(prod_i.lz) + off_term;
    // the farthest corner along the normal picks the larger product per axis
    max_x      = (prod_i.hx > prod_i.lx) ? prod_i.hx : prod_i.lx;
    max_y      = (prod_i.hy > prod_i.ly) ? prod_i.hy : prod_i.ly;
    max_z      = (prod_i.hz > prod_i.lz) ? prod_i.hz : prod_i.lz;
    dist_box   = DistW'(max_x) + DistW'(max_y) + DistW'(max_z) + off_term;
    neg_rad    = -$signed({{(DistW-RadW-OffShift){1'b0}}, rad_i, {OffShift{1'b0}}});
    margin_ext = $signed({{(DistW-MarginW){1'b0}}, margin_i});
    case (kind_i)
      KIND_POINT:  fail_o = (dist_pt <= margin_ext);
      KIND_SPHERE: fail_o = (dist_pt <= neg_rad);
      KIND_BOX:    fail_o = (dist_box <= $signed(DistW'(0)));
      default:     fail_o = 1'b1;
    endcase
  end

endmodule

[tb/frustum_cull_test_unit_tb.sv]
`timescale 1ns / 100ps

module frustum_cull_test_unit_tb;
  import fct_pkg::*;

  localparam int unsigned PlaneCount = 6;
  localparam int unsigned IdxW = $clog2(PlaneCount + 1);

  localparam logic [IdxW-1:0] REG_PLANE_RIGHT  = 3'd0;
  localparam logic [IdxW-1:0] REG_MARGIN       = 3'd6;
  localparam logic [IdxW-1:0] REG_UNUSED       = 3'd7;

  localparam bit PLANES_FRUSTUM   = 1'b0;
  localparam bit PLANES_ARBITRARY = 1'b1;

  localparam longint OffScale = longint'(1) << OffShift;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [IdxW-1:0]   cfg_idx = '0;
  logic [PlaneW-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  item_t             query_bus = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              inside_res;

  // mirror of the block's registers, at reset values
  plane_t            plane_mirror [PlaneCount] = '{default: '0};
  logic [MarginW-1:0] margin_mirror = 16'd1;

  logic              expected_inside [$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       err_count = 0;
  int unsigned       sent_count = 0;
  int unsigned       checked_count = 0;
  int unsigned       inside_count = 0;
  int unsigned       write_count = 0;
  int unsigned       setting_count = 0;

  frustum_cull_test_unit #(
    .PLANE_COUNT(PlaneCount)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (query_bus.kind),
    .first_x_i   (query_bus.lo_x),
    .first_y_i   (query_bus.lo_y),
    .first_z_i   (query_bus.lo_z),
    .second_x_i  (query_bus.hi_x),
    .second_y_i  (query_bus.hi_y),
    .second_z_i  (query_bus.hi_z),
    .radius_i    (query_bus.rad),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .inside_res_o(inside_res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // signed distance with 18 fraction bits
  function automatic longint plane_distance(int p, longint x, longint y, longint z);
    plane_t w;
    w = plane_mirror[p];
    return longint'(w.nx) * x + longint'(w.ny) * y + longint'(w.nz) * z
      + longint'(w.d) * OffScale;
  endfunction

  function automatic logic predict_inside(item_t q);
    longint lo [3];
    longint hi [3];
    logic   any_above;
    lo[0] = longint'(q.lo_x);
    lo[1] = longint'(q.lo_y);
    lo[2] = longint'(q.lo_z);
    hi[0] = longint'(q.hi_x);
    hi[1] = longint'(q.hi_y);
    hi[2] = longint'(q.hi_z);
    if (q.kind == KIND_UNUSED) return 1'b0;
    for (int p = 0; p < PlaneCount; p++) begin
      case (q.kind)
        KIND_POINT: begin
          if (plane_distance(p, lo[0], lo[1], lo[2]) <= longint'(margin_mirror)) return 1'b0;
        end
        KIND_SPHERE: begin
          if (plane_distance(p, lo[0], lo[1], lo[2]) <= -(longint'(q.rad) * OffScale))
            return 1'b0;
        end
        default: begin
          // corners taken from the two triples as given, even when reversed
          any_above = 1'b0;
          for (int c = 0; c < 8; c++) begin
            if (plane_distance(p, c[2] ? hi[0] : lo[0], c[1] ? hi[1] : lo[1],
                               c[0] ? hi[2] : lo[2]) > 0) any_above = 1'b1;
          end
          if (!any_above) return 1'b0;
        end
      endcase
    end
    return 1'b1;
  endfunction

  function automatic item_t make_query(logic [1:0] kind, int lx, int ly, int lz,
                                       int hx, int hy, int hz, int rad);
    item_t q;
    q.kind = kind;
    q.lo_x = CoordW'(lx);
    q.lo_y = CoordW'(ly);
    q.lo_z = CoordW'(lz);
    q.hi_x = CoordW'(hx);
    q.hi_y = CoordW'(hy);
    q.hi_z = CoordW'(hz);
    q.rad  = RadW'(rad);
    return q;
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(int v);
    if (v > 32767) return CoordW'(32767);
    if (v < -32768) return CoordW'(-32768);
    return CoordW'(v);
  endfunction

  // mostly near the frustum, now and then anywhere in the full range
  function automatic logic signed [CoordW-1:0] pick_coord(int span);
    if ($urandom_range(7) == 0) return CoordW'($urandom);
    return CoordW'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic item_t random_query(int span);
    item_t q;
    q.kind = ($urandom_range(19) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
    q.lo_x = pick_coord(span);
    q.lo_y = pick_coord(span);
    q.lo_z = pick_coord(span);
    q.hi_x = pick_coord(span);
    q.hi_y = pick_coord(span);
    q.hi_z = pick_coord(span);
    if ($urandom_range(9) == 0) q.rad = RadW'($urandom);
    else q.rad = RadW'($urandom_range(span / 2));
    // most boxes well formed, the rest keep independent corners
    if (q.kind == KIND_BOX && $urandom_range(4) != 0) begin
      q.hi_x = clamp_coord(int'(q.lo_x) + int'($urandom_range(span)));
      q.hi_y = clamp_coord(int'(q.lo_y) + int'($urandom_range(span)));
      q.hi_z = clamp_coord(int'(q.lo_z) + int'($urandom_range(span)));
    end
    return q;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic cfg_write(logic [IdxW-1:0] idx, logic [PlaneW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < PlaneCount) plane_mirror[idx] = data;
    else if (idx == REG_MARGIN) margin_mirror = data[MarginW-1:0];
    write_count++;
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic send_query(item_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    query_bus <= q;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_inside.push_back(predict_inside(q));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_inside.size() != 0) @(posedge clk);
  endtask

  // axis-aligned box frustum of the given half size, optionally tilted
  task automatic set_frustum(int half, bit jitter);
    plane_t pl;
    int     comp [3];
    int     axis;
    int     sgn;
    for (int p = 0; p < PlaneCount; p++) begin
      axis = p / 2;
      // right, top and far planes face the negative axis
      sgn = (p == 0 || p == 3 || p == 4) ? -1 : 1;
      for (int a = 0; a < 3; a++) comp[a] = jitter ? int'($urandom_range(3000)) - 1500 : 0;
      comp[axis] = sgn * (16384 - (jitter ? int'($urandom_range(2000)) : 0));
      pl.nx = CoordW'(comp[0]);
      pl.ny = CoordW'(comp[1]);
      pl.nz = CoordW'(comp[2]);
      pl.d  = CoordW'(jitter ? half + int'($urandom_range(half / 2)) - half / 4 : half);
      cfg_write(REG_PLANE_RIGHT + IdxW'(p), pl);
    end
  endtask

  task automatic test_reset_planes();
    // all distances are zero after reset
    send_query(make_query(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(KIND_SPHERE, 5, -5, 7, 0, 0, 0, 0));
    send_query(make_query(KIND_SPHERE, 5, -5, 7, 0, 0, 0, 1));
    send_query(make_query(KIND_BOX, -10, -10, -10, 10, 10, 10, 0));
    send_query(make_query(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_cube_frustum();
    wait_drained();
    set_frustum(1600, 1'b0);
    cfg_write(REG_MARGIN, PlaneW'(16'hFFFF));
    end_cfg();
    send_query(make_query(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
    // largest margin: one step past it passes, within it fails
    send_query(make_query(KIND_POINT, 1596, 0, 0, 0, 0, 0, 0));
    send_query(make_query(KIND_POINT, 1597, 0, 0, 0, 0, 0, 0));
    // sphere exactly touching from outside fails, one step bigger passes
    send_query(make_query(KIND_SPHERE, 1700, 0, 0, 0, 0, 0, 100));
    send_query(make_query(KIND_SPHERE, 1700, 0, 0, 0, 0, 0, 101));
    send_query(make_query(KIND_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
    send_query(make_query(KIND_BOX, 1700, 0, 0, 1800, 10, 10, 0));
    send_query(make_query(KIND_BOX, 1500, 0, 0, 1700, 10, 10, 0));
    // reversed boxes
    send_query(make_query(KIND_BOX, 100, 100, 100, -100, -100, -100, 0));
    send_query(make_query(KIND_BOX, 1800, 0, 0, 1700, 10, 10, 0));
    send_query(make_query(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    send_query(make_query(KIND_POINT, 32767, -32768, 32767, 0, 0, 0, 0));
    send_query(make_query(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 5));
    // write to the unused index must not touch the margin
    wait_drained();
    cfg_write(REG_MARGIN, '0);
    cfg_write(REG_UNUSED, '1);
    end_cfg();
    send_query(make_query(KIND_POINT, 1599, 0, 0, 0, 0, 0, 0));
    send_query(make_query(KIND_POINT, 1600, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_extreme_planes();
    logic [PlaneW-1:0]  pattern [2];
    logic [MarginW-1:0] margin [2];
    pattern[0] = 64'h7FFF_7FFF_7FFF_7FFF;
    pattern[1] = 64'h8000_8000_8000_8000;
    margin[0]  = '0;
    margin[1]  = '1;
    for (int k = 0; k < 2; k++) begin
      wait_drained();
      for (int p = 0; p < PlaneCount; p++) begin
        cfg_write(REG_PLANE_RIGHT + IdxW'(p), pattern[k]);
      end
      cfg_write(REG_MARGIN, PlaneW'(margin[k]));
      end_cfg();
      send_query(make_query(KIND_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
      send_query(make_query(KIND_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
      send_query(make_query(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
      send_query(make_query(KIND_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
    end
  endtask

  task automatic test_random(int count, bit planes_mode);
    int span;
    wait_drained();
    if (planes_mode == PLANES_ARBITRARY) begin
      for (int p = 0; p < PlaneCount; p++) begin
        cfg_write(REG_PLANE_RIGHT + IdxW'(p), {$urandom, $urandom});
      end
      span = 32767;
    end else begin
      span = $urandom_range(64, 8000);
      set_frustum(span, 1'b1);
      span = span + span / 2;
    end
    case ($urandom_range(2))
      0: cfg_write(REG_MARGIN, '0);
      1: cfg_write(REG_MARGIN, PlaneW'(16'hFFFF));
      default: cfg_write(REG_MARGIN, PlaneW'($urandom));
    endcase
    end_cfg();
    for (int i = 0; i < count; i++) begin
      // sender holds off once until the pipe is empty
      if (i == count / 3) wait_drained();
      send_query(random_query(span));
    end
  endtask

  always @(posedge clk) begin : check_result
    logic want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inside.size() == 0) begin
        report_mismatch("result with no query pending");
      end else begin
        want = expected_inside.pop_front();
        if (inside_res !== want)
          report_mismatch($sformatf("inside_res %b, expected %b (result %0d)",
                                    inside_res, want, checked_count));
        if (want) inside_count++;
        checked_count++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 46;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_planes();
    test_cube_frustum();
    test_extreme_planes();
    test_random(250, PLANES_FRUSTUM);
    test_random(250, PLANES_ARBITRARY);

    send_idle_pct = 46;
    recv_idle_pct = 30;
    test_random(250, PLANES_FRUSTUM);
    test_random(250, PLANES_FRUSTUM);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250, PLANES_FRUSTUM);
    test_random(250, PLANES_ARBITRARY);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("sent %0d queries, checked %0d results, %0d of them inside",
             sent_count, checked_count, inside_count);
    $display("%0d register writes over %0d plane settings, %0d mismatches",
             write_count, setting_count, err_count);
    if (err_count == 0) begin
      $display("PASS frustum_cull_test_unit");
    end else begin
      $display("FAIL frustum_cull_test_unit");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", expected_inside.size());
    $display("FAIL frustum_cull_test_unit");
    $finish;
  end

endmodule
